// ===== hw/rtl/bank_mapper_with_rtc_top_assert.svh =====
// assertion macros for the bank mapper with rtc
// used by bank_mapper_with_rtc_top.sv, expects i_clk and i_rst_n in scope
`ifndef BANK_MAPPER_WITH_RTC_TOP_ASSERT_SVH
`define BANK_MAPPER_WITH_RTC_TOP_ASSERT_SVH

// same-cycle implication
`define BMRTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BMRTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bmrtc_pkg.sv =====
// types and constants for the bank mapper with rtc
// no dependencies
`timescale 1ns / 1ps

package bmrtc_pkg;

    typedef enum logic [2:0] {
        TGT_COMMON = 3'd0,
        TGT_ROM    = 3'd1,
        TGT_RAM    = 3'd2,
        TGT_REG    = 3'd3,
        TGT_NONE   = 3'd4
    } t_target;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    localparam int unsigned CPS_W    = 25;
    localparam int unsigned ACC_W    = 24;
    localparam int unsigned PHYS_W   = 21;
    localparam int unsigned IN_DW    = 40;
    localparam int unsigned OUT_DW   = 32;

    localparam logic [CPS_W-1:0] CPS_RESET = 25'd4194304;
    localparam logic [ACC_W-1:0] ACC_MAX   = 24'hFFFFFF;

    localparam logic [3:0] ENABLE_CODE  = 4'hA;
    localparam logic [3:0] DISABLE_CODE = 4'h0;
    localparam logic [7:0] DAY_HI_MASK  = 8'hC1;
    localparam logic [7:0] DAY_CARRY    = 8'h80;
    localparam logic [7:0] DAY_BIT8_CLR = 8'hFE;
    localparam logic [7:0] OPEN_BUS     = 8'hFF;
    localparam int unsigned HALT_BIT    = 6;

    localparam logic [3:0] SEL_SEC    = 4'd8;
    localparam logic [3:0] SEL_MIN    = 4'd9;
    localparam logic [3:0] SEL_HOUR   = 4'd10;
    localparam logic [3:0] SEL_DAY_LO = 4'd11;
    localparam logic [3:0] SEL_DAY_HI = 4'd12;

    localparam logic [5:0] SEC_LIMIT  = 6'd60;
    localparam logic [5:0] MIN_LIMIT  = 6'd60;
    localparam logic [4:0] HOUR_LIMIT = 5'd24;

endpackage

// ===== hw/rtl/bank_mapper_with_rtc_top.sv =====
// cartridge bank mapper with real-time clock, single-pass datapath
// depends on bmrtc_pkg.sv and bank_mapper_with_rtc_top_assert.svh
//
//  channel  | direction | tdata                                  | tuser
//  s_axis   | in        | address, write_value, cycles           | req_type
//  m_axis   | out       | phys_address, read_data, ram_write,    | target
//           |           | ram_dirty                              |
//  cfg      | in        | cycles_per_second                      | -
//
// one request per cycle unless the result stalls; an accepted request loads the
// input register, and its decode and clock update then load the result register
// synchronous active-low reset sets rom bank 1, clears the clock and
// accumulator, and sets cycles_per_second to 4194304
// a stalled result holds; the input register takes a request only while it
// is empty or its request moves into the result register
`timescale 1ns / 1ps
`include "bank_mapper_with_rtc_top_assert.svh"

module bank_mapper_with_rtc_top #(
    parameter int unsigned ROM_BANK_BITS = 7,
    parameter int unsigned RAM_BANK_SIZE = 8192
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [15:0] address, [23:16] write_value, [39:24] cycles
    input  logic [bmrtc_pkg::IN_DW-1:0]       i_s_tdata,
    // [1:0] req_type
    input  logic [1:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [20:0] phys_address, [28:21] read_data, [29] ram_write, [30] ram_dirty,
    // [31] zero
    output logic [bmrtc_pkg::OUT_DW-1:0]      o_m_tdata,
    // [2:0] target
    output logic [2:0]                        o_m_tuser,
    input  logic                              i_cfg_we,
    input  logic [bmrtc_pkg::CPS_W-1:0]       i_cfg_wdata
);

    localparam int unsigned OffW = $clog2(RAM_BANK_SIZE);

    // input register
    logic                      r_in_valid;
    bmrtc_pkg::t_req           r_in_req;
    logic [15:0]               r_in_addr;
    logic [7:0]                r_in_val;
    logic [15:0]               r_in_cyc;

    // result register
    logic                          r_out_valid;
    bmrtc_pkg::t_target            r_out_target;
    logic [bmrtc_pkg::PHYS_W-1:0]  r_out_phys;
    logic [7:0]                    r_out_data;
    logic                          r_out_wr;
    logic                          r_out_dirty;

    // mapper and clock state
    logic [bmrtc_pkg::CPS_W-1:0]   r_cps;
    logic [ROM_BANK_BITS-1:0]      r_rom_bank;
    logic [3:0]                    r_ram_sel;
    logic                          r_ram_en;
    logic [7:0]                    r_last_latch;
    logic [5:0]                    r_sec;
    logic [5:0]                    r_min;
    logic [4:0]                    r_hour;
    logic [7:0]                    r_day_lo;
    logic [7:0]                    r_day_hi;
    logic [7:0]                    r_latched [5];
    logic [bmrtc_pkg::ACC_W-1:0]   r_acc;
    logic                          r_dirty;

    logic [ROM_BANK_BITS-1:0]      n_rom_bank;
    logic [3:0]                    n_ram_sel;
    logic                          n_ram_en;
    logic [7:0]                    n_last_latch;
    logic [5:0]                    n_sec;
    logic [5:0]                    n_min;
    logic [4:0]                    n_hour;
    logic [7:0]                    n_day_lo;
    logic [7:0]                    n_day_hi;
    logic                          n_latch;
    logic [bmrtc_pkg::ACC_W-1:0]   n_acc;
    logic                          n_dirty;

    bmrtc_pkg::t_target            n_target;
    logic [bmrtc_pkg::PHYS_W-1:0]  n_phys;
    logic [7:0]                    n_data;
    logic                          n_wr;

    logic                          adv;
    logic                          step;
    logic                          in_ram_win;
    logic [bmrtc_pkg::PHYS_W-1:0]  ram_phys;
    logic [bmrtc_pkg::PHYS_W-1:0]  rom_phys;
    logic [ROM_BANK_BITS-1:0]      bank_wr;

    // one-second advance
    logic [5:0]                    sec_inc;
    logic [5:0]                    min_inc;
    logic [4:0]                    hour_inc;
    logic [7:0]                    day_inc;
    logic                          c_sec;
    logic                          c_min;
    logic                          c_hour;
    logic                          c_day;
    logic [5:0]                    a_sec;
    logic [5:0]                    a_min;
    logic [4:0]                    a_hour;
    logic [7:0]                    a_day_lo;
    logic [7:0]                    a_day_hi;

    // tick accumulator
    logic [bmrtc_pkg::CPS_W-1:0]   sum;
    logic                          sum_ge;
    logic [bmrtc_pkg::CPS_W-1:0]   sum_sub;

    assign adv        = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && adv;
    assign o_s_tready = !r_in_valid || adv;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_target;
    assign o_m_tdata  = {1'b0, r_out_dirty, r_out_wr, r_out_data, r_out_phys};

    assign in_ram_win = (r_in_addr[15:13] == 3'b101);
    assign ram_phys   = bmrtc_pkg::PHYS_W'({r_ram_sel[1:0], r_in_addr[OffW-1:0]});
    assign rom_phys   = bmrtc_pkg::PHYS_W'({r_rom_bank, r_in_addr[13:0]});
    assign bank_wr    = ROM_BANK_BITS'(r_in_val);

    assign sec_inc  = r_sec + 6'd1;
    assign min_inc  = r_min + 6'd1;
    assign hour_inc = r_hour + 5'd1;
    assign day_inc  = r_day_lo + 8'd1;
    assign c_sec    = (sec_inc == bmrtc_pkg::SEC_LIMIT);
    assign c_min    = c_sec && (min_inc == bmrtc_pkg::MIN_LIMIT);
    assign c_hour   = c_min && (hour_inc == bmrtc_pkg::HOUR_LIMIT);
    assign c_day    = c_hour && (day_inc == 8'd0);
    assign a_sec    = c_sec ? 6'd0 : sec_inc;
    assign a_min    = c_sec ? (c_min ? 6'd0 : min_inc) : r_min;
    assign a_hour   = c_min ? (c_hour ? 5'd0 : hour_inc) : r_hour;
    assign a_day_lo = c_hour ? day_inc : r_day_lo;
    assign a_day_hi = !c_day ? r_day_hi :
                      r_day_hi[0] ? ((r_day_hi & bmrtc_pkg::DAY_BIT8_CLR)
                                     | bmrtc_pkg::DAY_CARRY)
                                  : (r_day_hi | 8'h01);

    assign sum     = bmrtc_pkg::CPS_W'(r_acc) + bmrtc_pkg::CPS_W'(r_in_cyc);
    assign sum_ge  = (sum >= r_cps);
    assign sum_sub = sum_ge ? (sum - r_cps) : sum;

    always_comb begin
        n_rom_bank   = r_rom_bank;
        n_ram_sel    = r_ram_sel;
        n_ram_en     = r_ram_en;
        n_last_latch = r_last_latch;
        n_sec        = r_sec;
        n_min        = r_min;
        n_hour       = r_hour;
        n_day_lo     = r_day_lo;
        n_day_hi     = r_day_hi;
        n_latch      = 1'b0;
        n_acc        = r_acc;
        n_dirty      = r_dirty;
        n_target     = bmrtc_pkg::TGT_NONE;
        n_phys       = '0;
        n_data       = 8'd0;
        n_wr         = 1'b0;

        case (r_in_req)
            bmrtc_pkg::REQ_READ: begin
                if (r_in_addr[15:14] == 2'b00) begin
                    n_target = bmrtc_pkg::TGT_ROM;
                    n_phys   = bmrtc_pkg::PHYS_W'(r_in_addr);
                end else if (r_in_addr[15:14] == 2'b01) begin
                    n_target = bmrtc_pkg::TGT_ROM;
                    n_phys   = rom_phys;
                end else if (in_ram_win) begin
                    n_target = bmrtc_pkg::TGT_REG;
                    n_data   = bmrtc_pkg::OPEN_BUS;
                    if (r_ram_en) begin
                        if (r_ram_sel[3:2] == 2'b00) begin
                            n_target = bmrtc_pkg::TGT_RAM;
                            n_data   = 8'd0;
                            n_phys   = ram_phys;
                        end else if (r_ram_sel >= bmrtc_pkg::SEL_SEC &&
                                     r_ram_sel <= bmrtc_pkg::SEL_DAY_HI) begin
                            n_data = r_latched[3'(r_ram_sel - bmrtc_pkg::SEL_SEC)];
                        end
                    end
                end else begin
                    n_target = bmrtc_pkg::TGT_COMMON;
                end
            end
            bmrtc_pkg::REQ_WRITE: begin
                if (r_in_addr[15:13] == 3'b000) begin
                    if (r_in_val[3:0] == bmrtc_pkg::ENABLE_CODE) begin
                        n_ram_en = 1'b1;
                    end else if (r_in_val[3:0] == bmrtc_pkg::DISABLE_CODE) begin
                        n_ram_en = 1'b0;
                    end
                end else if (r_in_addr[15:13] == 3'b001) begin
                    n_rom_bank = (bank_wr == '0) ? ROM_BANK_BITS'(1) : bank_wr;
                end else if (r_in_addr[15:13] == 3'b010) begin
                    n_ram_sel = r_in_val[3:0];
                end else if (r_in_addr[15:13] == 3'b011) begin
                    n_latch      = (r_in_val == 8'd1) && (r_last_latch == 8'd0);
                    n_last_latch = r_in_val;
                end else if (in_ram_win) begin
                    if (r_ram_en) begin
                        if (r_ram_sel[3:2] == 2'b00) begin
                            n_target = bmrtc_pkg::TGT_RAM;
                            n_wr     = 1'b1;
                            n_phys   = ram_phys;
                            n_dirty  = 1'b1;
                        end else begin
                            unique case (r_ram_sel)
                                bmrtc_pkg::SEL_SEC:    n_sec    = r_in_val[5:0];
                                bmrtc_pkg::SEL_MIN:    n_min    = r_in_val[5:0];
                                bmrtc_pkg::SEL_HOUR:   n_hour   = r_in_val[4:0];
                                bmrtc_pkg::SEL_DAY_LO: n_day_lo = r_in_val;
                                bmrtc_pkg::SEL_DAY_HI:
                                    n_day_hi = r_in_val & bmrtc_pkg::DAY_HI_MASK;
                                default: ;
                            endcase
                        end
                    end
                end else begin
                    n_target = bmrtc_pkg::TGT_COMMON;
                end
            end
            bmrtc_pkg::REQ_TICK: begin
                if (!r_day_hi[bmrtc_pkg::HALT_BIT]) begin
                    if (sum_ge) begin
                        n_sec    = a_sec;
                        n_min    = a_min;
                        n_hour   = a_hour;
                        n_day_lo = a_day_lo;
                        n_day_hi = a_day_hi;
                    end
                    n_acc = sum_sub[bmrtc_pkg::CPS_W-1] ? bmrtc_pkg::ACC_MAX
                                                        : sum_sub[bmrtc_pkg::ACC_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cps        <= bmrtc_pkg::CPS_RESET;
            r_rom_bank   <= ROM_BANK_BITS'(1);
            r_ram_sel    <= 4'd0;
            r_ram_en     <= 1'b0;
            r_last_latch <= 8'd0;
            r_sec        <= 6'd0;
            r_min        <= 6'd0;
            r_hour       <= 5'd0;
            r_day_lo     <= 8'd0;
            r_day_hi     <= 8'd0;
            r_acc        <= '0;
            r_dirty      <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_latched[i] <= 8'd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cps <= i_cfg_wdata;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_rom_bank   <= n_rom_bank;
                r_ram_sel    <= n_ram_sel;
                r_ram_en     <= n_ram_en;
                r_last_latch <= n_last_latch;
                r_sec        <= n_sec;
                r_min        <= n_min;
                r_hour       <= n_hour;
                r_day_lo     <= n_day_lo;
                r_day_hi     <= n_day_hi;
                r_acc        <= n_acc;
                r_dirty      <= n_dirty;
                if (n_latch) begin
                    r_latched[0] <= {2'b00, r_sec};
                    r_latched[1] <= {2'b00, r_min};
                    r_latched[2] <= {3'b000, r_hour};
                    r_latched[3] <= r_day_lo;
                    r_latched[4] <= r_day_hi;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_req  <= bmrtc_pkg::t_req'(i_s_tuser);
            r_in_addr <= i_s_tdata[15:0];
            r_in_val  <= i_s_tdata[23:16];
            r_in_cyc  <= i_s_tdata[39:24];
        end
        if (step) begin
            r_out_target <= n_target;
            r_out_phys   <= n_phys;
            r_out_data   <= n_data;
            r_out_wr     <= n_wr;
            r_out_dirty  <= n_dirty;
        end
    end

    `BMRTC_ASSERT_NOW(a_rom_bank_nonzero, 1'b1, r_rom_bank != '0, "rom bank is zero")
    `BMRTC_ASSERT_NOW(a_wr_is_ram, r_out_valid && r_out_wr, r_out_target == bmrtc_pkg::TGT_RAM, "ram write without ram target")
    `BMRTC_ASSERT_NOW(a_reg_no_addr, r_out_valid && r_out_target == bmrtc_pkg::TGT_REG, r_out_phys == '0, "register data with address")
    `BMRTC_ASSERT_NEXT(a_dirty_sticky, r_dirty, r_dirty, "dirty flag dropped")
    `BMRTC_ASSERT_NEXT(a_halt_holds_acc, step && r_in_req == bmrtc_pkg::REQ_TICK && r_day_hi[bmrtc_pkg::HALT_BIT], $stable(r_acc) && $stable(r_sec), "halted clock moved")

endmodule
